FILE: rtl/tlii_pkg.sv
// Package: shared constants and types for the interpolation unit.
`default_nettype none
package tlii_pkg;
    localparam int MaxKnotsDefault = 64;
    localparam logic [0:0] OP_LOAD  = 1'b0;
    localparam logic [0:0] OP_QUERY = 1'b1;
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_RANGE  = 2'd1;
    localparam logic [1:0] STATUS_WIDTH  = 2'd2;

    typedef struct packed {
        logic [0:0]         op;
        logic [5:0]         knot_index;
        logic signed [31:0] knot_x;
        logic signed [31:0] knot_y;
        logic signed [31:0] query_z;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] interp_value;
        logic signed [47:0] integral_value;
        logic [1:0]         status;
    } out_item_t;
endpackage
`default_nettype wire

FILE: rtl/tlii_if.sv
// Interfaces: valid/ready channels carrying input and result items.
`default_nettype none
interface tlii_in_if
    import tlii_pkg::*;
;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tlii_out_if
    import tlii_pkg::*;
;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/table_linear_interp_integral_unit.sv
// Top level: piecewise linear interpolation and integral over a knot table.
//
// Usage:
//   in_ch carries one transaction per item: op selects a knot load or a query.
//   A load writes one knot into the on-chip tables and returns an all-zero
//   result with status ok. A query finds the segment holding query_z by
//   bisection over knots_in_use knots, walks segments from the first knot to
//   that segment summing trapezoid areas, then divides once to interpolate.
//   out_ch returns one result transaction per item.
// Flow: a query walks segments through the single memory read port and
//   then runs the bit-serial divider. One item is in flight at a time.
// Reset: rst_n clears the sequencer and sets knots_in_use to 2; knot
//   contents are undefined until loaded.
// Stall: a result held in the output register waits for out_ch.ready; no
//   new transaction is taken until it leaves.
// Write knots_in_use through cfg_we/cfg_data only while idle (not enforced).
`default_nettype none
module table_linear_interp_integral_unit
    import tlii_pkg::*;
#(
    parameter int MAX_KNOTS = MaxKnotsDefault
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [6:0] cfg_data,
    tlii_in_if.sink         in_ch,
    tlii_out_if.source      out_ch
);
    logic [6:0] knots_in_use_reg;

    // Hold the knot count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            knots_in_use_reg <= 7'd2;
        else if (cfg_we)
            knots_in_use_reg <= cfg_data;
    end

    tlii_core #(.MAX_KNOTS(MAX_KNOTS)) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .knots_in_use (knots_in_use_reg),
        .in_ch        (in_ch),
        .out_ch       (out_ch)
    );
endmodule
`default_nettype wire

FILE: rtl/tlii_divider.sv
// Divider: restoring unsigned division, one quotient bit per cycle.
`default_nettype none
module tlii_divider
    import tlii_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [32:0] divisor,
    output logic             done,
    output logic [63:0]      quotient
);
    logic [63:0] q_reg, q_next;
    logic [33:0] r_reg, r_next;
    logic [32:0] d_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [33:0] shifted;

    always_comb
    begin
        shifted   = {r_reg[32:0], q_reg[63]};
        q_next    = {q_reg[62:0], 1'b0};
        r_next    = shifted;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, d_reg})
            begin
                r_next    = shifted - {1'b0, d_reg};
                q_next[0] = 1'b1;
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
                busy_next = 1'b0;
        end
        else
        begin
            q_next = q_reg;
            r_next = r_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start)
            d_reg <= divisor;
    end

    assign done     = busy_reg && (cnt_reg == 7'd1) && !start;
    assign quotient = q_next;
endmodule
`default_nettype wire

FILE: rtl/tlii_core.sv
// Core: knot memories and the query sequencer.
`default_nettype none
module tlii_core
    import tlii_pkg::*;
#(
    parameter int MAX_KNOTS = MaxKnotsDefault
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic [6:0] knots_in_use,
    tlii_in_if.sink   in_ch,
    tlii_out_if.source out_ch
);
    localparam int AW = (MAX_KNOTS > 2) ? $clog2(MAX_KNOTS) : 1;
    localparam int CW = AW + 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD0   = 4'd1;
    localparam logic [3:0] S_CHK0  = 4'd2;
    localparam logic [3:0] S_CHKN  = 4'd3;
    localparam logic [3:0] S_BIS   = 4'd4;
    localparam logic [3:0] S_BISW  = 4'd5;
    localparam logic [3:0] S_WRD   = 4'd6;
    localparam logic [3:0] S_WA    = 4'd7;
    localparam logic [3:0] S_WB    = 4'd8;
    localparam logic [3:0] S_WMUL  = 4'd9;
    localparam logic [3:0] S_DIV   = 4'd10;
    localparam logic [3:0] S_PMUL  = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    logic signed [31:0] mem_x [MAX_KNOTS];
    logic signed [31:0] mem_y [MAX_KNOTS];
    logic [AW-1:0]      raddr;
    logic signed [31:0] rx, ry;

    logic [3:0]  state_reg, state_next;
    logic [CW-1:0] n_reg, i_reg, j_reg, k_reg;
    logic signed [31:0] z_reg, x0_reg, y0_reg;
    logic signed [33:0] sum_reg;
    logic [32:0] w_reg;
    logic signed [33:0] dy_reg;
    logic signed [64:0] prod_reg;
    logic signed [49:0] acc_reg;
    logic signed [33:0] v_reg;
    out_item_t out_reg;
    logic out_valid_reg;

    logic [CW-1:0] mid;
    logic [CW-1:0] n_clamp;
    logic          div_start, div_done;
    logic [63:0]   div_q;
    logic [32:0]   dz_w;
    logic signed [32:0] dx_s;
    logic signed [64:0] prod_now;
    logic [65:0]   mag_prod;
    logic signed [50:0] acc_sum;

    always_comb
    begin
        if (knots_in_use < 7'd2)
            n_clamp = CW'(2);
        else if ({25'd0, knots_in_use} > 32'(MAX_KNOTS))
            n_clamp = CW'(MAX_KNOTS);
        else
            n_clamp = CW'(knots_in_use);
    end

    assign mid = CW'(({1'b0, i_reg} + {1'b0, j_reg}) >> 1);

    // Memory write on load, single read port.
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready && in_ch.data.op == OP_LOAD
            && {26'd0, in_ch.data.knot_index} < 32'(MAX_KNOTS))
        begin
            mem_x[AW'(in_ch.data.knot_index)] <= in_ch.data.knot_x;
            mem_y[AW'(in_ch.data.knot_index)] <= in_ch.data.knot_y;
        end
        rx <= mem_x[raddr];
        ry <= mem_y[raddr];
    end

    // Issue the bisection probe and the segment end in the cycle before their use.
    always_comb
    begin
        if (state_reg == S_BIS)
            raddr = AW'(mid);
        else if (state_reg == S_WA)
            raddr = AW'(k_reg + CW'(1));
        else
            raddr = AW'(k_reg);
    end

    assign in_ch.ready   = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_ch.valid  = out_valid_reg;
    assign out_ch.data   = out_reg;

    assign dx_s = {rx[31], rx} - {x0_reg[31], x0_reg};
    assign dz_w = 33'({z_reg[31], z_reg} - {x0_reg[31], x0_reg});
    assign div_start = (state_reg == S_WMUL) && (k_reg == i_reg + CW'(1));
    assign prod_now  = 65'(dy_reg) * 65'($signed({1'b0, dz_w}));

    tlii_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_now[64] ? 64'(-prod_now) : 64'(prod_now)),
        .divisor  (w_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    logic signed [33:0] tsum;
    logic [32:0] tw;
    logic [33:0] tmag;
    always_comb
    begin
        tsum = sum_reg;
        tw   = w_reg;
        tmag = tsum[33] ? 34'(-tsum) : 34'(tsum);
        mag_prod = 66'(tmag) * 66'(tw);
    end

    logic signed [49:0] term;
    always_comb
    begin
        term = sum_reg[33] ? -50'(mag_prod[65:17]) : 50'(mag_prod[65:17]);
        acc_sum = 51'(acc_reg) + 51'(term);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_ch.valid && out_ch.ready)
                out_valid_reg <= 1'b0;
            if (state_reg == S_OUT || (state_reg == S_IDLE && in_ch.valid
                && in_ch.ready && in_ch.data.op == OP_LOAD))
                out_valid_reg <= 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_ch.valid && in_ch.ready && in_ch.data.op == OP_QUERY)
                    state_next = S_RD0;
            S_RD0:  state_next = S_CHK0;
            S_CHK0: state_next = S_CHKN;
            S_CHKN: state_next = S_BIS;
            S_BIS:  state_next = S_BISW;
            S_BISW: state_next = S_BIS;
            S_WRD:  state_next = S_WA;
            S_WA:   state_next = S_WB;
            S_WB:   state_next = S_WMUL;
            S_WMUL: state_next = S_WRD;
            S_DIV:  state_next = S_DIV;
            S_PMUL: state_next = S_FIN;
            S_FIN:  state_next = S_OUT;
            S_OUT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_CHKN && (z_reg < x0_reg || z_reg > rx))
            state_next = S_OUT;
        if (state_reg == S_BIS && j_reg - i_reg <= CW'(1))
            state_next = S_WRD;
        if (state_reg == S_WB && dx_s <= 0)
            state_next = S_OUT;
        if (state_reg == S_WMUL && k_reg == i_reg + CW'(1))
            state_next = S_DIV;
        if (state_reg == S_DIV && div_done)
            state_next = S_PMUL;
    end

    // Datapath: walk segments 0..i, accumulate whole trapezoids, then
    // interpolate and add the partial trapezoid.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (in_ch.valid && in_ch.ready)
                begin
                    z_reg   <= in_ch.data.query_z;
                    n_reg   <= n_clamp;
                    k_reg   <= '0;
                    acc_reg <= '0;
                    out_reg <= '0;
                end
            S_RD0:
                k_reg <= n_reg - CW'(1);
            S_CHK0:
            begin
                x0_reg <= rx;
            end
            S_CHKN:
            begin
                i_reg <= '0;
                j_reg <= n_reg - CW'(1);
                if (z_reg < x0_reg || z_reg > rx)
                    out_reg.status <= STATUS_RANGE;
            end
            S_BIS:
                if (j_reg - i_reg <= CW'(1))
                    k_reg <= '0;
                else
                    k_reg <= mid;
            S_BISW:
                if (z_reg > rx)
                    i_reg <= k_reg;
                else
                    j_reg <= k_reg;
            S_WA:
            begin
                x0_reg <= rx;
                y0_reg <= ry;
                k_reg  <= k_reg + CW'(1);
            end
            S_WB:
            begin
                if (dx_s <= 0)
                    out_reg.status <= STATUS_WIDTH;
                w_reg   <= 33'(dx_s);
                sum_reg <= 34'(y0_reg) + 34'(ry);
                dy_reg  <= 34'(ry) - 34'(y0_reg);
            end
            S_WMUL:
            begin
                if (k_reg == i_reg + CW'(1))
                begin
                    prod_reg <= prod_now;
                end
                else
                    acc_reg <= acc_sum[49:0];
            end
            S_DIV:
                if (div_done)
                    v_reg <= 34'(y0_reg) + (prod_reg[64] ? -34'(div_q) : 34'(div_q));
            S_PMUL:
            begin
                sum_reg <= 34'(y0_reg) + v_reg;
                w_reg   <= dz_w;
            end
            S_FIN:
            begin
                acc_reg <= acc_sum[49:0];
                if (v_reg > 34'sd2147483647)
                    out_reg.interp_value <= 32'h7fffffff;
                else if (v_reg < -34'sd2147483648)
                    out_reg.interp_value <= 32'h80000000;
                else
                    out_reg.interp_value <= v_reg[31:0];
            end
            S_OUT:
                if (out_reg.status == STATUS_OK)
                begin
                    if (acc_reg > 50'sh7fffffffffff)
                        out_reg.integral_value <= 48'h7fffffffffff;
                    else if (acc_reg < -50'sh800000000000)
                        out_reg.integral_value <= 48'h800000000000;
                    else
                        out_reg.integral_value <= acc_reg[47:0];
                end
                else
                begin
                    out_reg.interp_value   <= '0;
                    out_reg.integral_value <= '0;
                end
            default: ;
        endcase
    end

    property p_no_accept_busy;
        @(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ch.ready;
    endproperty
    a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

    property p_out_from_idle;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |=> (state_reg == S_IDLE);
    endproperty
    a_out_from_idle: assert property (p_out_from_idle) else $error("bad return");

    property p_bis_order;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_BIS) |-> (i_reg < j_reg);
    endproperty
    a_bis_order: assert property (p_bis_order) else $error("bisection order");
endmodule
`default_nettype wire
